>>> hdl/md5_password_search_assert.svh
// assertion macros for the md5 password search block
// used by the top level and the target table
`ifndef MD5_PASSWORD_SEARCH_ASSERT_SVH
`define MD5_PASSWORD_SEARCH_ASSERT_SVH
// a condition that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// a condition that implies another on the next edge
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

>>> hdl/mps_pkg.sv
// shared types and constants for the md5 password search block
// no dependencies
package mps_pkg;
  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_TEST  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIGITS, S_HASH, S_SCAN, S_DONE
  } state_t;

  // request to the md5 round unit and its answer
  typedef struct packed {
    logic        start;
    logic [63:0] text;
  } hash_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] digest;
  } hash_rsp_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
      4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
      4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'ha: r = 5'd16; 4'hb: r = 5'd23;
      4'hc: r = 5'd6;  4'hd: r = 5'd10; 4'he: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction
endpackage

>>> hdl/md5_password_search.sv
// md5 password search: top level with control, valid bits and result register
// depends on mps_pkg, mps_md5_round, mps_target_table and the assert header
//
// one input channel s_axis_* and one output channel m_axis_*; every input beat
// gives exactly one output beat. mode is carried in s_axis_tuser.
// clear, load and unused-mode beats, and out-of-range tests, put their result
// on m_axis in the cycle after the input beat. a test beat converts the index to
// base 26 one digit per cycle, then takes a closing step that copies out the
// text; with no targets left the result follows that step with no hash.
// otherwise the md5 round unit runs 64 rounds, one a cycle, then hands over
// the digest, then the target memory is scanned
// one slot per cycle through its single read port, ending early on a hit.
// one item is in flight at a time; s_axis_tready is high only while idle, as
// after a result beat, so the next input beat can follow in the cycle after it.
// the result register holds until m_axis_tready is seen high.
// reset clears the valid bits, the tested count and the control state; digest
// memory is undefined until loaded and never matched for an invalid slot.
module md5_password_search #(
  parameter int TARGET_SLOTS = 16,
  parameter int PASSWORD_LENGTH = 6
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot[3:0], digest_high[67:4], digest_low[131:68], candidate_index[160:132]
  input  logic [167:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // match[0], match_slot[4:1], password_text[52:5], remaining[57:53],
  // status[59:58], tested[91:60]
  output logic [95:0]  m_axis_tdata
);
  import mps_pkg::*;
  `include "md5_password_search_assert.svh"

  localparam int SW = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
  localparam int CW = $clog2(TARGET_SLOTS + 1);
  localparam int LW = $clog2(PASSWORD_LENGTH + 1);
  localparam logic [37:0] Bound = 38'(64'd26 ** PASSWORD_LENGTH);
  // ceil(2^34 / 26), exact quotient for any 29-bit dividend
  localparam logic [29:0] Recip26 = 30'd660764200;

  state_t state, state_next;

  logic [1:0]  in_mode;
  logic [3:0]  in_slot;
  logic [28:0] in_index;
  assign in_mode  = s_axis_tuser;
  assign in_slot  = s_axis_tdata[3:0];
  assign in_index = s_axis_tdata[160:132];

  logic [TARGET_SLOTS-1:0] valid;
  logic [31:0] tested;
  logic [28:0] quot;
  logic [58:0] quot_prod;
  logic [28:0] quot_div;
  logic [28:0] quot_rem;
  logic [LW-1:0] dig_cnt;
  logic [63:0] text_le;   // first char in byte 0
  logic [SW:0] scan;      // read address counter, one ahead of compare
  logic        scan_hit;
  logic [SW-1:0] hit_slot;
  logic [127:0] digest;
  logic        empty_item;

  logic        out_match;
  logic [3:0]  out_slot;
  logic [47:0] out_text;
  logic [1:0]  out_status;

  hash_req_t hreq;
  hash_rsp_t hrsp;

  logic        tbl_wr, tbl_rd;
  logic [127:0] tbl_q;
  logic [SW-1:0] rd_addr, cmp_addr;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  mps_md5_round #(.PasswordLength(PASSWORD_LENGTH)) u_round (
    .clk(clk), .rst(rst), .req(hreq), .rsp(hrsp)
  );

  mps_target_table #(.Slots(TARGET_SLOTS)) u_table (
    .clk(clk), .rst(rst),
    .wr_en(tbl_wr), .wr_addr(in_slot[SW-1:0]),
    .wr_data({s_axis_tdata[67:4], s_axis_tdata[131:68]}),
    .rd_en(tbl_rd), .rd_addr(rd_addr), .rd_data(tbl_q)
  );

  assign tbl_wr = accept && in_mode == MODE_LOAD && 32'(in_slot) < TARGET_SLOTS;
  assign rd_addr = scan[SW-1:0];
  assign cmp_addr = SW'(scan[SW-1:0] - SW'(1));

  // divide by 26 through a reciprocal multiply, remainder by shift and add
  assign quot_prod = {30'd0, quot} * {29'd0, Recip26};
  assign quot_div  = {4'd0, quot_prod[58:34]};
  assign quot_rem  = quot - ((quot_div << 4) + (quot_div << 3) + (quot_div << 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) begin
        if (in_mode == MODE_TEST && {9'd0, in_index} < Bound) state_next = S_DIGITS;
        else state_next = S_DONE;
      end
      S_DIGITS: if (dig_cnt == LW'(PASSWORD_LENGTH)) begin
        state_next = (valid == '0) ? S_DONE : S_HASH;
      end
      S_HASH: if (hrsp.done) state_next = S_SCAN;
      S_SCAN: if (scan_hit || scan == (SW + 1)'(TARGET_SLOTS)) state_next = S_DONE;
      S_DONE: if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = state == S_IDLE;
    m_axis_tvalid = state == S_DONE;
    hreq.start = state == S_DIGITS && dig_cnt == LW'(PASSWORD_LENGTH) && valid != '0;
    hreq.text  = text_le;
    tbl_rd = state == S_SCAN && scan < (SW + 1)'(TARGET_SLOTS);
  end

  // compare the slot read last cycle
  always_comb begin
    scan_hit = 1'b0;
    hit_slot = cmp_addr;
    if (state == S_SCAN && scan != '0)
      scan_hit = valid[cmp_addr] && tbl_q == digest;
  end

  logic [CW-1:0] count;
  always_comb begin
    count = '0;
    for (int j = 0; j < TARGET_SLOTS; j++) count = count + CW'(valid[j]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      valid  <= '0;
      tested <= '0;
    end else begin
      state <= state_next;
      if (accept && in_mode == MODE_CLEAR) valid <= '0;
      if (tbl_wr) valid[in_slot[SW-1:0]] <= 1'b1;
      if (hrsp.done) tested <= tested + 32'd1;
      if (scan_hit) valid[hit_slot] <= 1'b0;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      quot <= in_index;
      dig_cnt <= '0;
      text_le <= '0;
      out_match <= 1'b0;
      out_slot <= '0;
      out_text <= '0;
      out_status <= (in_mode == MODE_TEST && {9'd0, in_index} >= Bound) ? ST_RANGE : ST_OK;
    end
    if (state == S_DIGITS) begin
      if (dig_cnt != LW'(PASSWORD_LENGTH)) begin
        // least significant digit is the last character
        text_le[(PASSWORD_LENGTH - 1 - 32'(dig_cnt)) * 8 +: 8] <=
          8'h61 + {3'd0, quot_rem[4:0]};
        quot <= quot_div;
        dig_cnt <= dig_cnt + LW'(1);
      end else begin
        for (int j = 0; j < 6; j++)
          if (j < PASSWORD_LENGTH)
            out_text[j * 8 +: 8] <= text_le[(PASSWORD_LENGTH - 1 - j) * 8 +: 8];
        if (valid == '0) out_status <= ST_EMPTY;
      end
    end
    if (hrsp.done) digest <= hrsp.digest;
    if (state == S_HASH) scan <= '0;
    else if (state == S_SCAN) scan <= scan + (SW + 1)'(1);
    if (scan_hit) begin
      out_match <= 1'b1;
      out_slot <= 4'(hit_slot);
    end
  end

  assign empty_item = valid == '0;
  assign m_axis_tdata = {4'd0, tested, out_status, 5'(count), out_text, out_slot, out_match};

  `ASSERT_NEXT(a_one_result, accept, !s_axis_tready, "new beat taken while busy")
  `ASSERT_ALWAYS(a_hash_nonempty, !(hreq.start && empty_item), "hash started with no targets")
  `ASSERT_NEXT(a_hit_clears, scan_hit, !valid[$past(hit_slot)], "matched slot still valid")
endmodule

>>> hdl/mps_md5_round.sv
// md5 round unit: one round per cycle over a single padded block
// depends on mps_pkg; message words come from the packed candidate text
module mps_md5_round #(
  parameter int PasswordLength = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  mps_pkg::hash_req_t req,
  output mps_pkg::hash_rsp_t rsp
);
  import mps_pkg::*;

  localparam logic [31:0] BitLen = 32'(PasswordLength * 8);

  logic [31:0] a, b, c, d;
  logic [5:0]  rnd;
  logic        busy;
  logic        done_q;
  logic [127:0] dg;
  logic [31:0] w [16];
  logic [31:0] f, wg, sum, rot;
  logic [3:0]  g;
  logic [4:0]  s;

  // block words: text is little-endian bytes, first char in byte 0
  always_comb begin
    for (int j = 0; j < 16; j++) w[j] = '0;
    for (int j = 0; j < PasswordLength; j++)
      w[j / 4][(j % 4) * 8 +: 8] = req.text[j * 8 +: 8];
    w[PasswordLength / 4][(PasswordLength % 4) * 8 +: 8] = 8'h80;
    w[14] = BitLen;
  end

  always_comb begin
    case (rnd[5:4])
      2'd0: begin f = (b & c) | (~b & d); g = rnd[3:0]; end
      2'd1: begin f = (d & b) | (~d & c); g = 4'(rnd * 5 + 1); end
      2'd2: begin f = b ^ c ^ d;          g = 4'(rnd * 3 + 5); end
      default: begin f = c ^ (b | ~d);    g = 4'(rnd * 7); end
    endcase
    wg  = w[g];
    s   = rot_amt(rnd);
    sum = a + f + round_k(rnd) + wg;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  // text must be held by the caller for the whole hash
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      rnd    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rnd  <= '0;
        a <= 32'h67452301; b <= 32'hefcdab89;
        c <= 32'h98badcfe; d <= 32'h10325476;
      end else if (busy) begin
        a <= d; d <= c; c <= b; b <= b + rot;
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  logic [31:0] st0, st1, st2, st3;
  assign st0 = 32'h67452301 + a;
  assign st1 = 32'hefcdab89 + b;
  assign st2 = 32'h98badcfe + c;
  assign st3 = 32'h10325476 + d;
  // digest byte 0 is low byte of st0, placed most significant
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      dg[127 - j * 8 -: 8] = st0[j * 8 +: 8];
      dg[95 - j * 8 -: 8]  = st1[j * 8 +: 8];
      dg[63 - j * 8 -: 8]  = st2[j * 8 +: 8];
      dg[31 - j * 8 -: 8]  = st3[j * 8 +: 8];
    end
  end

  assign rsp = {done_q, dg};
endmodule

>>> hdl/mps_target_table.sv
// target digest memory: one synchronous ram with registered read data
// depends on mps_pkg for nothing but style; valid bits live in the top level
module mps_target_table #(
  parameter int Slots = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(Slots)-1:0] wr_addr,
  input  logic [127:0]             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Slots)-1:0] rd_addr,
  output logic [127:0]             rd_data
);
  import mps_pkg::*;
  `include "md5_password_search_assert.svh"

  logic [127:0] mem [Slots];
  logic         rd_en_q;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_en_q <= 1'b0;
    else rd_en_q <= rd_en;
  end

  // the scan never reads while a load is writing
  `ASSERT_ALWAYS(a_no_rw_overlap, !(wr_en && rd_en), "table read and write together")
  `ASSERT_NEXT(a_rd_tracks, rd_en, rd_en_q, "read enable not tracked")
endmodule

>>> tb/sv/md5_search_checker.sv
// checker for the md5 password search block: tracks the target table, hashes
// candidates itself and compares every output beat; depends on mps_pkg
module md5_search_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  output int           fail_count,
  output int           pending,
  output int           match_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import mps_pkg::*;

  localparam int SLOTS = 16;
  localparam int PW_LEN = 6;
  localparam logic [28:0] INDEX_BOUND = 29'd308915776;  // 26^6

  typedef struct packed {
    logic        match;
    logic [3:0]  match_slot;
    logic [47:0] password_text;
    logic [4:0]  remaining;
    status_t     status;
    logic [31:0] tested;
  } search_result_t;

  logic [63:0] tgt_high [SLOTS];
  logic [63:0] tgt_low [SLOTS];
  logic [SLOTS-1:0] tgt_valid;
  logic [31:0] hashed_total;
  search_result_t expected_results [$];

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // password as big-endian ascii, first character in the top byte
  function automatic logic [47:0] password_of(input logic [28:0] idx);
    logic [47:0] txt;
    logic [28:0] n;
    txt = '0;
    n = idx;
    for (int k = 0; k < PW_LEN; k++) begin
      txt[8*k +: 8] = 8'h61 + 8'(n % 26);
      n = n / 26;
    end
    return txt;
  endfunction

  // digest bytes 0..15 with byte 0 in the top bits
  function automatic logic [127:0] md5_of_password(input logic [47:0] txt);
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t, sum;
    logic [31:0] h [4];
    logic [127:0] dg;
    int g, s;
    for (int i = 0; i < 16; i++) w[i] = '0;
    for (int i = 0; i < PW_LEN; i++)
      w[i/4][8*(i%4) +: 8] = txt[8*(PW_LEN-1-i) +: 8];
    w[PW_LEN/4][8*(PW_LEN%4) +: 8] = 8'h80;
    w[14] = PW_LEN * 8;
    a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin f = (b & c) | (~b & d); g = i; end
      else if (i < 32) begin f = (d & b) | (~d & c); g = (5*i + 1) % 16; end
      else if (i < 48) begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
      else begin f = c ^ (b | ~d); g = (7*i) % 16; end
      s = SHIFTS[(i/16)*4 + i%4];
      sum = a + f + SINE_K[i] + w[g];
      t = d; d = c; c = b;
      b = b + ((sum << s) | (sum >> (32 - s)));
      a = t;
    end
    h[0] = 32'h67452301 + a; h[1] = 32'hefcdab89 + b;
    h[2] = 32'h98badcfe + c; h[3] = 32'h10325476 + d;
    for (int i = 0; i < 16; i++) dg[127 - 8*i -: 8] = h[i/4][8*(i%4) +: 8];
    return dg;
  endfunction

  function automatic search_result_t search_step(input mode_t mode, input logic [3:0] slot,
      input logic [63:0] dh, input logic [63:0] dl, input logic [28:0] idx);
    search_result_t r;
    logic [127:0] dg;
    r = '0;
    r.status = ST_OK;
    case (mode)
      MODE_CLEAR: tgt_valid = '0;
      MODE_LOAD: begin
        tgt_high[slot] = dh;
        tgt_low[slot] = dl;
        tgt_valid[slot] = 1'b1;
      end
      MODE_TEST: begin
        if (idx >= INDEX_BOUND) r.status = ST_RANGE;
        else begin
          r.password_text = password_of(idx);
          if (tgt_valid == '0) r.status = ST_EMPTY;
          else begin
            dg = md5_of_password(r.password_text);
            hashed_total++;
            for (int i = 0; i < SLOTS; i++)
              if (!r.match && tgt_valid[i] && {tgt_high[i], tgt_low[i]} == dg) begin
                tgt_valid[i] = 1'b0;
                r.match = 1'b1;
                r.match_slot = 4'(i);
              end
          end
        end
      end
      default: ;
    endcase
    r.remaining = 5'($countones(tgt_valid));
    r.tested = hashed_total;
    return r;
  endfunction

  always @(posedge clk) begin
    search_result_t exp_r, got;
    if (rst) begin
      tgt_valid <= '0;
      hashed_total <= '0;
      fail_count <= 0;
      match_count <= 0;
      pending <= 0;
      expected_results.delete();
    end else begin
      // output first: a new expectation cannot be due in the same beat
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[52:5], m_axis_tdata[57:53],
               m_axis_tdata[59:58], m_axis_tdata[91:60]};
        if (expected_results.size() == 0) begin
          $error("output beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            fail_count <= fail_count + 1;
            if (got.match != exp_r.match)
              $error("match: expected %0d actual %0d", exp_r.match, got.match);
            if (got.match_slot != exp_r.match_slot)
              $error("match_slot: expected %0d actual %0d", exp_r.match_slot, got.match_slot);
            if (got.password_text != exp_r.password_text)
              $error("password_text: expected %h actual %h",
                     exp_r.password_text, got.password_text);
            if (got.remaining != exp_r.remaining)
              $error("remaining: expected %0d actual %0d", exp_r.remaining, got.remaining);
            if (got.status != exp_r.status)
              $error("status: expected %0d actual %0d", exp_r.status, got.status);
            if (got.tested != exp_r.tested)
              $error("tested: expected %0d actual %0d", exp_r.tested, got.tested);
          end
          if (exp_r.match) match_count <= match_count + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(search_step(mode_t'(s_axis_tuser), s_axis_tdata[3:0],
            s_axis_tdata[67:4], s_axis_tdata[131:68], s_axis_tdata[160:132]));
      pending <= expected_results.size();
    end
  end
endmodule

>>> tb/sv/tb_top.sv
// top of the md5 password search testbench: clock, reset, input and output
// beats, verdict; depends on mps_pkg, md5_search_checker and the block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mps_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int INDEX_BOUND = 308915776;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  int fail_count, pending, match_count;
  longint cycle_count = 0;
  bit rx_quiet = 1'b0;
  int rx_hold = 0;
  int n_beats = 0;

  always #5 clk = ~clk;

  md5_password_search u_top (.*);

  md5_search_checker u_chk (.*);

  // digests of known candidates, filled in by the checker's hash function
  logic [127:0] known_digest [8];
  int known_index [8];

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic send_beat(input mode_t mode, input logic [3:0] slot,
      input logic [127:0] dg, input logic [28:0] idx);
    int g;
    g = gap_len();
    if (s_axis_tvalid && g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tuser <= mode;
    s_axis_tdata <= {7'd0, idx, dg[63:0], dg[127:64], slot};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    n_beats++;
  endtask

  task automatic load_target(input logic [3:0] slot, input int k);
    send_beat(MODE_LOAD, slot, known_digest[k], 29'($urandom));
  endtask

  task automatic test_index(input int idx);
    send_beat(MODE_TEST, 4'($urandom), {$urandom, $urandom, $urandom, $urandom}, 29'(idx));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: mostly short stalls, now and then a long one
  always @(negedge clk) begin
    if (rx_quiet) m_axis_tready <= 1'b1;
    else if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(0, 99) < 3) begin
      m_axis_tready <= 1'b0;
      rx_hold <= $urandom_range(10, 80);
    end else m_axis_tready <= ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int k, sel;
    logic [127:0] rnd;
    known_index = '{0, INDEX_BOUND - 1, 1, 25, 26, 12345, 200000000, 99999};
    for (int i = 0; i < 8; i++)
      known_digest[i] = u_chk.md5_of_password(u_chk.password_of(29'(known_index[i])));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, range, extremes, overwrite, duplicates, unused mode
    test_index(0);
    test_index(INDEX_BOUND);
    test_index(29'h1fffffff);
    send_beat(MODE_NONE, 4'hf, '1, '1);
    load_target(4'd0, 0);
    load_target(4'd15, 1);
    send_beat(MODE_LOAD, 4'd7, '1, '1);
    send_beat(MODE_LOAD, 4'd8, '0, '0);
    test_index(INDEX_BOUND);
    test_index(0);
    test_index(INDEX_BOUND - 1);
    test_index(5);
    load_target(4'd3, 2);
    load_target(4'd9, 2);
    load_target(4'd3, 3);
    load_target(4'd3, 2);
    test_index(1);
    test_index(1);
    test_index(1);
    send_beat(MODE_NONE, 4'd0, '0, 29'd1);
    send_beat(MODE_CLEAR, 4'd0, '0, '0);
    test_index(25);
    rx_quiet = 1'b1;
    drain();
    rx_quiet = 1'b0;

    // random: a mix of target loads and tests of known candidates, with noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, 7);
      rnd = {$urandom, $urandom, $urandom, $urandom};
      if (sel < 3) send_beat(MODE_CLEAR, 4'($urandom), rnd, 29'($urandom));
      else if (sel < 25) load_target(4'($urandom), k);
      else if (sel < 32) send_beat(MODE_LOAD, 4'($urandom), rnd, 29'($urandom));
      else if (sel < 35) send_beat(MODE_NONE, 4'($urandom), rnd, 29'($urandom));
      else if (sel < 70) test_index(known_index[k]);
      else if (sel < 78) test_index($urandom_range(INDEX_BOUND, 29'h1fffffff));
      else test_index($urandom_range(0, INDEX_BOUND - 1));
      if (n == RANDOM_ITEMS / 2) drain();
    end
    drain();
    repeat (200) @(negedge clk);
    $display("covered %0d input beats, %0d target hits, clear/load/test and unused mode",
             n_beats, match_count);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> files.f
+incdir+hdl
hdl/mps_pkg.sv
hdl/mps_md5_round.sv
hdl/mps_target_table.sv
hdl/md5_password_search.sv
tb/sv/md5_search_checker.sv
tb/sv/tb_top.sv
